[hdl/bsad_pkg.sv]
// ----------------------------------------------------------------------------
// bsad_pkg - shared types and constants for the block SAD engine
// Sizes, register indexes, the configuration struct and the entry format of
// the queue between the front and back parts.
// ----------------------------------------------------------------------------
package bsad_pkg;

  localparam int MAX_BLOCK_WIDTH  = 64;
  localparam int MAX_BLOCK_HEIGHT = 64;
  localparam int CHUNK_PIXELS     = 16;
  localparam int PIX_W            = 8;

  // Effective size limits in register widths
  localparam logic [2:0] MAX_CHUNKS = 3'(MAX_BLOCK_WIDTH / CHUNK_PIXELS);
  localparam logic [6:0] MAX_ROWS   = 7'(MAX_BLOCK_HEIGHT);

  localparam int SAD_W     = 20;
  localparam int CHUNK_W   = 12;  // sum of 16 absolute differences
  localparam logic [SAD_W-1:0] SAD_MAX = '1;

  localparam int QUEUE_DEPTH = 4;  // power of two
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNKS_PER_ROW = 2'd0,
    REG_BLOCK_HEIGHT   = 2'd1,
    REG_AVERAGE_ENABLE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] chunks_per_row;
    logic [6:0] block_height;
    logic       average_enable;
  } cfg_t;

  typedef struct packed {
    logic                                last;
    logic [CHUNK_PIXELS-1:0][PIX_W-1:0]  diff;
  } q_entry_t;

endpackage

[hdl/block_sad_with_compound_average.sv]
// ----------------------------------------------------------------------------
// block_sad_with_compound_average - block sum of absolute differences
// Accumulates |src - ref| (or |src - round((ref+pred)/2)|) over a block of
// 16-pixel chunks and delivers one total per block.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: present 16 source, reference and second-prediction pixels
//   (one row chunk) and raise in_push; the chunk transfers at a clock edge
//   with in_push high and in_full low. Chunks arrive in row-major order.
//   Result queue: while out_empty is low, out_block_sad holds the oldest
//   block total; it transfers at an edge with out_pop high.
//   Config: write cfg_wdata to register cfg_index when cfg_we is high
//   (0 chunks per row, 1 block height, 2 average enable); write only while
//   no chunk is in flight.
// Timing: one chunk per cycle sustained while in_full is low. The total of a
//   block passes the front register, queue, chunk adder tree and accumulation
//   into the result buffer before it can be popped.
// Reset (synchronous, rst_n low): empty all stages, clear block position and
//   accumulator, registers back to 1 chunk, 16 rows, no averaging.
// Stall: when out_pop stays low the two-entry result buffer fills, the back
//   stops at the next last chunk, the four-entry queue fills and then
//   in_full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module block_sad_with_compound_average import bsad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [63:0]           in_src_lo,
  input  logic [63:0]           in_src_hi,
  input  logic [63:0]           in_ref_lo,
  input  logic [63:0]           in_ref_hi,
  input  logic [63:0]           in_pred_lo,
  input  logic [63:0]           in_pred_hi,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [SAD_W-1:0]      out_block_sad,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_in, q_head;

  // Register file: mask each write to the register width, drop unknown indexes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CHUNKS_PER_ROW: cfg_nxt.chunks_per_row = cfg_wdata[2:0];
        REG_BLOCK_HEIGHT:   cfg_nxt.block_height   = cfg_wdata[6:0];
        REG_AVERAGE_ENABLE: cfg_nxt.average_enable = cfg_wdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunks_per_row <= 3'd1;
      cfg_r.block_height   <= 7'd16;
      cfg_r.average_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: take a chunk, mark the last one of the block, form differences
  bsad_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_src_lo  (in_src_lo),
    .in_src_hi  (in_src_hi),
    .in_ref_lo  (in_ref_lo),
    .in_ref_hi  (in_ref_hi),
    .in_pred_lo (in_pred_lo),
    .in_pred_hi (in_pred_hi),
    .q_push     (q_push),
    .q_entry    (q_in),
    .q_full     (q_full)
  );

  // Queue: decouple intake from accumulation
  bsad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // Back: sum the chunk, accumulate the block, buffer totals
  bsad_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_block_sad (out_block_sad)
  );

endmodule

[hdl/bsad_front.sv]
// ----------------------------------------------------------------------------
// bsad_front - chunk intake and classification
// Tracks the chunk position in the block, flags the last chunk and forms the
// per-pixel absolute differences, optionally against the rounded average.
// ----------------------------------------------------------------------------
module bsad_front import bsad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_src_lo,
  input  logic [63:0] in_src_hi,
  input  logic [63:0] in_ref_lo,
  input  logic [63:0] in_ref_hi,
  input  logic [63:0] in_pred_lo,
  input  logic [63:0] in_pred_hi,
  output logic        q_push,
  output q_entry_t    q_entry,
  input  logic        q_full
);

  logic       valid_r, valid_nxt;
  q_entry_t   entry_r, entry_nxt;
  logic [1:0] col_r, col_nxt;
  logic [5:0] row_r, row_nxt;
  logic       accept;
  logic [2:0] eff_chunks;
  logic [6:0] eff_rows;
  logic [2:0] col_inc;
  logic [6:0] row_inc;
  logic       last;
  logic [127:0] src_w, ref_w, pred_w;
  logic [CHUNK_PIXELS-1:0][PIX_W-1:0] diff;

  assign q_push  = valid_r & ~q_full;
  assign q_entry = entry_r;
  assign in_full = valid_r & q_full;
  assign accept  = in_push & ~in_full;

  assign src_w  = {in_src_hi, in_src_lo};
  assign ref_w  = {in_ref_hi, in_ref_lo};
  assign pred_w = {in_pred_hi, in_pred_lo};

  // clamp sizes: zero means one, oversize saturates
  always_comb begin
    if (cfg.chunks_per_row == 3'd0)         eff_chunks = 3'd1;
    else if (cfg.chunks_per_row > MAX_CHUNKS) eff_chunks = MAX_CHUNKS;
    else                                    eff_chunks = cfg.chunks_per_row;
    if (cfg.block_height == 7'd0)           eff_rows = 7'd1;
    else if (cfg.block_height > MAX_ROWS)   eff_rows = MAX_ROWS;
    else                                    eff_rows = cfg.block_height;
  end

  always_comb begin
    logic [PIX_W:0]   avg_sum;
    logic [PIX_W-1:0] s, r;
    for (int k = 0; k < CHUNK_PIXELS; k++) begin
      s       = src_w[PIX_W*k +: PIX_W];
      avg_sum = {1'b0, ref_w[PIX_W*k +: PIX_W]} + {1'b0, pred_w[PIX_W*k +: PIX_W]}
                + {{PIX_W{1'b0}}, 1'b1};
      r       = cfg.average_enable ? avg_sum[PIX_W:1] : ref_w[PIX_W*k +: PIX_W];
      diff[k] = (s > r) ? (s - r) : (r - s);
    end
  end

  always_comb begin
    col_inc = {1'b0, col_r} + 3'd1;
    row_inc = {1'b0, row_r} + 7'd1;
    col_nxt = col_r;
    row_nxt = row_r;
    last    = 1'b0;
    if (accept) begin
      if (col_inc < eff_chunks) begin
        col_nxt = col_inc[1:0];
      end else begin
        col_nxt = 2'd0;
        if (row_inc < eff_rows) begin
          row_nxt = row_inc[5:0];
        end else begin
          row_nxt = 6'd0;
          last    = 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (q_push) valid_nxt = 1'b0;
    if (accept) begin
      valid_nxt      = 1'b1;
      entry_nxt.diff = diff;
      entry_nxt.last = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      col_r   <= 2'd0;
      row_r   <= 6'd0;
    end else begin
      valid_r <= valid_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
    entry_r <= entry_nxt;
  end

endmodule

[hdl/bsad_queue.sv]
// ----------------------------------------------------------------------------
// bsad_queue - short queue between front and back
// Holds classified chunks so that each side can stall on its own.
// ----------------------------------------------------------------------------
module bsad_queue import bsad_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty
);

  q_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

[hdl/bsad_back.sv]
// ----------------------------------------------------------------------------
// bsad_back - chunk summation, block accumulation and result buffer
// Sums the 16 differences of a chunk, accumulates over the block and hands
// the block total to a two-entry result buffer.
// ----------------------------------------------------------------------------
module bsad_back import bsad_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  q_entry_t         q_head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [SAD_W-1:0] out_block_sad
);

  logic               s1_v_r, s1_v_nxt;
  logic [CHUNK_W-1:0] s1_sum_r;
  logic               s1_last_r;
  logic               s1_go, s1_ready;
  logic [SAD_W-1:0]   acc_r, acc_nxt;
  logic [SAD_W:0]     total_w;
  logic [SAD_W-1:0]   total;
  logic [CHUNK_W-1:0] chunk_sum;

  logic [8:0]  lv1 [8];
  logic [9:0]  lv2 [4];
  logic [10:0] lv3 [2];

  logic [SAD_W-1:0] ob_r [2];
  logic             ob_wr_r, ob_rd_r;
  logic [1:0]       ob_cnt_r, ob_cnt_nxt;
  logic             ob_full, ob_push, ob_pop;

  // adder tree over the chunk
  always_comb begin
    for (int i = 0; i < 8; i++)
      lv1[i] = {1'b0, q_head.diff[2*i]} + {1'b0, q_head.diff[2*i+1]};
    for (int i = 0; i < 4; i++)
      lv2[i] = {1'b0, lv1[2*i]} + {1'b0, lv1[2*i+1]};
    for (int i = 0; i < 2; i++)
      lv3[i] = {1'b0, lv2[2*i]} + {1'b0, lv2[2*i+1]};
    chunk_sum = {1'b0, lv3[0]} + {1'b0, lv3[1]};
  end

  assign ob_full  = (ob_cnt_r == 2'd2);
  assign s1_go    = s1_v_r & (~s1_last_r | ~ob_full);
  assign s1_ready = ~s1_v_r | s1_go;
  assign q_pop    = s1_ready & ~q_empty;

  assign total_w = {1'b0, acc_r} + {{(SAD_W+1-CHUNK_W){1'b0}}, s1_sum_r};
  assign total   = total_w[SAD_W] ? SAD_MAX : total_w[SAD_W-1:0];

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_go) s1_v_nxt = 1'b0;
    if (q_pop) s1_v_nxt = 1'b1;
    acc_nxt = acc_r;
    if (s1_go) acc_nxt = s1_last_r ? '0 : total;
  end

  assign ob_push       = s1_go & s1_last_r;
  assign out_empty     = (ob_cnt_r == 2'd0);
  assign ob_pop        = out_pop & ~out_empty;
  assign out_block_sad = ob_r[ob_rd_r];

  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    if (ob_push && !ob_pop)      ob_cnt_nxt = ob_cnt_r + 2'd1;
    else if (!ob_push && ob_pop) ob_cnt_nxt = ob_cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      acc_r    <= '0;
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      s1_v_r   <= s1_v_nxt;
      acc_r    <= acc_nxt;
      ob_cnt_r <= ob_cnt_nxt;
      if (ob_push) ob_wr_r <= ~ob_wr_r;
      if (ob_pop)  ob_rd_r <= ~ob_rd_r;
    end
    if (q_pop) begin
      s1_sum_r  <= chunk_sum;
      s1_last_r <= q_head.last;
    end
    if (ob_push) ob_r[ob_wr_r] <= total;
  end

endmodule
